### hw/rtl/mbfr_pkg.sv
`default_nettype none

package mbfr_pkg;

  // Default sizes of the bit buffer and of the widest field read.
  localparam int BUFFER_BYTES_DEFAULT   = 8;
  localparam int MAX_FIELD_BITS_DEFAULT = 32;

  // Request codes.
  localparam logic [2:0] FUNC_PUSH     = 3'd0;
  localparam logic [2:0] FUNC_UNSIGNED = 3'd1;
  localparam logic [2:0] FUNC_SIGNED   = 3'd2;
  localparam logic [2:0] FUNC_U8       = 3'd3;
  localparam logic [2:0] FUNC_LE16     = 3'd4;
  localparam logic [2:0] FUNC_LE32     = 3'd5;
  localparam logic [2:0] FUNC_ALIGN    = 3'd6;

  // Result status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SHORT    = 2'd1;
  localparam logic [1:0] STATUS_TOO_WIDE = 2'd2;
  localparam logic [1:0] STATUS_FULL     = 2'd3;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] byte_in;
    logic [5:0] bit_count;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } out_item_t;

endpackage

`default_nettype wire

### hw/rtl/msb_first_bitfield_reader_unit.sv
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | in_data  (func, byte_in, bit_count)
// out     | output    | out_valid / out_ready | out_data (value, status)
//
// Every input transaction gives exactly one result transaction, registered and offered in the next cycle.
// One item is taken per cycle unless a pending result is held by a low out_ready; the buffer update and
// the result are both formed in the same cycle by combinational shifts over the bit buffer.
// Reset empties the buffer and drops any pending result.
// While a result waits for out_ready, in_ready is low; it rises again in the cycle
// the result is taken, so a steady stream with out_ready high runs at full rate.
`default_nettype none

module msb_first_bitfield_reader_unit #(
  parameter int BUFFER_BYTES   = mbfr_pkg::BUFFER_BYTES_DEFAULT,
  parameter int MAX_FIELD_BITS = mbfr_pkg::MAX_FIELD_BITS_DEFAULT
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  mbfr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output mbfr_pkg::out_item_t out_data
);
  import mbfr_pkg::*;

  localparam int BUF_BITS = BUFFER_BYTES * 8;
  // User must keep at least 32 buffer bits so fill is never narrower than bit_count; not enforced by the block.
  localparam int FILL_W   = $clog2(BUF_BITS + 1);

  // Oldest bit sits at the top of the buffer; unused bits below are kept zero.
  logic [BUF_BITS-1:0] buffer, buffer_next;
  logic [FILL_W-1:0]   fill, fill_next;
  out_item_t           result;
  logic                in_fire;

  logic [2:0]          partial;
  logic [FILL_W-1:0]   aligned;
  logic [FILL_W-1:0]   need;
  logic [FILL_W-1:0]   count;
  logic [BUF_BITS-1:0] aligned_buf;
  logic [31:0]         top_raw;
  logic [31:0]         top_al;
  logic [31:0]         field_val;
  logic [31:0]         low_mask;
  logic                sign_bit;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Shared views: raw and byte-aligned top words of the buffer, the field at the top and its sign bit.
  always_comb begin
    partial     = fill[2:0];
    aligned     = fill - FILL_W'(partial);
    count       = FILL_W'(in_data.bit_count);
    aligned_buf = buffer << partial;
    top_raw     = buffer[BUF_BITS-1 -: 32];
    top_al      = aligned_buf[BUF_BITS-1 -: 32];
    field_val   = top_raw >> (6'd32 - in_data.bit_count);
    low_mask    = 32'((33'd1 << in_data.bit_count) - 33'd1);
    sign_bit    = |(field_val & (low_mask ^ (low_mask >> 1)));
  end

  // Request decode, buffer update and result formation.
  always_comb begin
    buffer_next = buffer;
    fill_next   = fill;
    result      = '0;
    need        = '0;
    unique case (in_data.func)
      FUNC_PUSH: begin
        if (fill > FILL_W'(BUF_BITS - 8)) begin
          result.status = STATUS_FULL;
        end else begin
          buffer_next = buffer | ({in_data.byte_in, {(BUF_BITS-8){1'b0}}} >> fill);
          fill_next   = fill + FILL_W'(8);
        end
      end
      FUNC_UNSIGNED, FUNC_SIGNED: begin
        priority if (in_data.bit_count > 6'(MAX_FIELD_BITS)) begin
          result.status = STATUS_TOO_WIDE;
        end else if (in_data.bit_count == 6'd0) begin
          result.value = '0;
        end else if (count > fill) begin
          result.status = STATUS_SHORT;
        end else begin
          buffer_next  = buffer << in_data.bit_count;
          fill_next    = fill - count;
          result.value = field_val;
          if (in_data.func == FUNC_SIGNED && sign_bit) begin
            result.value = field_val | ~low_mask;
          end
        end
      end
      FUNC_U8, FUNC_LE16, FUNC_LE32: begin
        unique case (in_data.func)
          FUNC_U8:   need = FILL_W'(8);
          FUNC_LE16: need = FILL_W'(16);
          default:   need = FILL_W'(32);
        endcase
        if (aligned < need) begin
          result.status = STATUS_SHORT;
        end else begin
          buffer_next = aligned_buf << need;
          fill_next   = aligned - need;
          // First byte read lands in the low byte of the value.
          unique case (in_data.func)
            FUNC_U8:   result.value = {24'd0, top_al[31:24]};
            FUNC_LE16: result.value = {16'd0, top_al[23:16], top_al[31:24]};
            default:   result.value = {top_al[7:0], top_al[15:8],
                                       top_al[23:16], top_al[31:24]};
          endcase
        end
      end
      FUNC_ALIGN: begin
        buffer_next = aligned_buf;
        fill_next   = aligned;
      end
      default: begin
        result = '0;
      end
    endcase
  end

  // Buffer state and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer    <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else if (in_fire) begin
      buffer    <= buffer_next;
      fill      <= fill_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= result;
    end
  end

  // The fill level never passes the buffer size.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(BUF_BITS))
    else $error("bit buffer fill above capacity");

  // A push that fits grows the fill by one byte.
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_data.func == FUNC_PUSH && fill <= FILL_W'(BUF_BITS - 8)
    |=> fill == $past(fill) + FILL_W'(8))
    else $error("accepted push did not add one byte");

  // Any failing status carries a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != STATUS_OK |-> out_data.value == 32'd0)
    else $error("non-ok result with nonzero value");

  // With no result pending the input side is always open.
  a_ready_open: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

`default_nettype wire

### bench/msb_first_bitfield_reader_unit_test.sv
`default_nettype none

module msb_first_bitfield_reader_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mbfr_pkg::*;

  localparam int         CAP_BITS       = BUFFER_BYTES_DEFAULT * 8;
  localparam int         FIELD_LIMIT    = MAX_FIELD_BITS_DEFAULT;
  localparam logic [2:0] FUNC_UNUSED    = 3'd7;
  localparam int         STALL_LIMIT    = 1000;
  localparam int         RANDOM_PHASE_N = 400;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Shadow copy of the bit buffer, newest bits in the low end.
  logic [127:0] stream_bits = '0;
  int           fill_bits = 0;

  out_item_t expected_results[$];
  int        error_count = 0;
  int        requests_sent = 0;
  int        status_tally[4] = '{0, 0, 0, 0};
  int        send_idle_pct = 0;
  int        sink_stall_pct = 0;
  int        quiet_cycles = 0;

  msb_first_bitfield_reader_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Keep only the buffered bits; everything above the fill level is zero.
  function automatic void trim_to_fill();
    stream_bits &= ~({128{1'b1}} << fill_bits);
  endfunction

  // Remove the n oldest buffered bits (1 to 32) and return them MSB first.
  function automatic logic [31:0] pull_oldest_bits(int n);
    logic [127:0] shifted;
    logic [63:0]  field_mask;
    shifted    = stream_bits >> (fill_bits - n);
    field_mask = (64'd1 << n) - 64'd1;
    fill_bits -= n;
    trim_to_fill();
    return shifted[31:0] & field_mask[31:0];
  endfunction

  // Work out the result of one request and advance the shadow buffer.
  function automatic out_item_t predict_result(in_item_t req);
    out_item_t   res;
    int          nbytes;
    int          aligned;
    logic [63:0] low_mask;
    res = '0;
    res.status = STATUS_OK;
    case (req.func)
      FUNC_PUSH: begin
        if (fill_bits + 8 > CAP_BITS) begin
          res.status = STATUS_FULL;
        end else begin
          stream_bits = (stream_bits << 8) | 128'(req.byte_in);
          fill_bits += 8;
          trim_to_fill();
        end
      end
      FUNC_UNSIGNED, FUNC_SIGNED: begin
        if (req.bit_count > FIELD_LIMIT) begin
          res.status = STATUS_TOO_WIDE;
        end else if (req.bit_count == 0) begin
          res.value = '0;
        end else if (req.bit_count > fill_bits) begin
          res.status = STATUS_SHORT;
        end else begin
          res.value = pull_oldest_bits(req.bit_count);
          // Sign extension applies only below the full 32-bit width.
          if (req.func == FUNC_SIGNED && req.bit_count < 32 &&
              res.value[req.bit_count - 1]) begin
            low_mask = (64'd1 << req.bit_count) - 64'd1;
            res.value |= ~low_mask[31:0];
          end
        end
      end
      FUNC_U8, FUNC_LE16, FUNC_LE32: begin
        nbytes  = (req.func == FUNC_U8) ? 1 : (req.func == FUNC_LE16) ? 2 : 4;
        aligned = fill_bits - (fill_bits % 8);
        if (aligned < nbytes * 8) begin
          res.status = STATUS_SHORT;
        end else begin
          fill_bits = aligned;
          trim_to_fill();
          for (int i = 0; i < nbytes; i++) begin
            res.value |= pull_oldest_bits(8) << (8 * i);
          end
        end
      end
      FUNC_ALIGN: begin
        fill_bits -= fill_bits % 8;
        trim_to_fill();
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Drive one request and hold it until the block takes it.
  task automatic send_request(input logic [2:0] func, input logic [7:0] byte_val,
                              input logic [5:0] count);
    in_item_t req;
    req.func      = func;
    req.byte_in   = byte_val;
    req.bit_count = count;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  // Pick a request, pushing more often when the buffer runs low.
  task automatic send_random_request();
    int         pick;
    int         push_pct;
    logic [2:0] func;
    logic [5:0] count;
    pick     = $urandom_range(99);
    push_pct = (fill_bits < 32) ? 65 : (fill_bits >= 56) ? 25 : 40;
    count    = ($urandom_range(9) == 0) ? 6'($urandom_range(33, 63))
                                        : 6'($urandom_range(0, 32));
    if (pick < push_pct) begin
      func = FUNC_PUSH;
    end else if (pick < 93) begin
      case ($urandom_range(6))
        0, 1:    func = FUNC_UNSIGNED;
        2, 3:    func = FUNC_SIGNED;
        4:       func = FUNC_U8;
        5:       func = FUNC_LE16;
        default: func = FUNC_LE32;
      endcase
    end else if (pick < 97) begin
      func = FUNC_ALIGN;
    end else begin
      // Noise: any selector with any count, unused one included.
      func  = 3'($urandom_range(7));
      count = 6'($urandom_range(63));
    end
    send_request(func, 8'($urandom), count);
  endtask

  // Every read on an empty buffer, plus the count checks and unused selector.
  task automatic test_empty_buffer();
    send_request(FUNC_UNSIGNED, 8'h00, 6'd1);
    send_request(FUNC_SIGNED,   8'hFF, 6'd5);
    send_request(FUNC_U8,       8'h00, 6'd0);
    send_request(FUNC_LE16,     8'h00, 6'd0);
    send_request(FUNC_LE32,     8'h00, 6'd0);
    send_request(FUNC_UNSIGNED, 8'h00, 6'd0);
    send_request(FUNC_SIGNED,   8'h00, 6'd33);
    send_request(FUNC_UNSIGNED, 8'hFF, 6'd63);
    send_request(FUNC_ALIGN,    8'h00, 6'd0);
    send_request(FUNC_UNUSED,   8'hFF, 6'd63);
  endtask

  // Fill to capacity, overflow once, then drain through unsigned, signed, LE16, align and LE32 requests.
  task automatic test_fill_and_drain();
    logic [7:0] pattern[8] = '{8'hFF, 8'h00, 8'h80, 8'h7F, 8'hA5, 8'h5A, 8'h01, 8'hFE};
    foreach (pattern[i]) send_request(FUNC_PUSH, pattern[i], 6'd0);
    send_request(FUNC_PUSH,     8'h3C, 6'd0);
    send_request(FUNC_UNSIGNED, 8'h00, 6'd32);
    send_request(FUNC_SIGNED,   8'h00, 6'd3);
    send_request(FUNC_LE16,     8'h00, 6'd0);
    send_request(FUNC_SIGNED,   8'h00, 6'd1);
    send_request(FUNC_ALIGN,    8'h00, 6'd0);
    send_request(FUNC_LE32,     8'h00, 6'd0);
    // Refill and read a full-width signed field, then a little-endian 32-bit word.
    foreach (pattern[i]) send_request(FUNC_PUSH, ~pattern[i], 6'd0);
    send_request(FUNC_SIGNED,   8'h00, 6'd32);
    send_request(FUNC_LE32,     8'h00, 6'd0);
  endtask

  // Mixed traffic under random idling on both sides.
  task automatic test_random_with_gaps();
    send_idle_pct  = 15;
    sink_stall_pct = 15;
    repeat (RANDOM_PHASE_N) send_random_request();
  endtask

  // Back-to-back traffic with both sides always ready.
  task automatic test_random_full_rate();
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    repeat (RANDOM_PHASE_N) send_random_request();
  endtask

  // The receiver applies random back-pressure on every cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Predict on each accepted request and check each accepted result.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request pending, got value %h status %0d",
                   $time, out_data.value, out_data.status);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.value !== want.value) begin
            $display("%0t: value mismatch, expected %h, got %h",
                     $time, want.value, out_data.value);
            error_count++;
          end
          if (out_data.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_data.status);
            error_count++;
          end
          status_tally[want.status]++;
        end
      end
      if (in_valid && in_ready) begin
        expected_results = {expected_results, predict_result(in_data)};
      end
    end
  end

  // End the run if no transaction moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, expected_results.size());
      $display("[msb_first_bitfield_reader_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_buffer();
    test_fill_and_drain();
    test_random_with_gaps();
    test_random_full_rate();
    test_random_with_gaps();
    in_valid <= 1'b0;
    sink_stall_pct = 15;
    // Let the checker record the last accepted request before draining.
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("Sent %0d requests; results: %0d ok, %0d short, %0d too wide, %0d dropped pushes.",
             requests_sent, status_tally[STATUS_OK], status_tally[STATUS_SHORT],
             status_tally[STATUS_TOO_WIDE], status_tally[STATUS_FULL]);
    $display("Directed empty and full buffer cases, then random traffic with and without idling.");
    if (error_count == 0) begin
      $display("[msb_first_bitfield_reader_unit] OK");
    end else begin
      $display("[msb_first_bitfield_reader_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
